// ===== sv/ax25_header_parser_macros.svh =====
// Assertion helpers shared by the parser modules.
// Each expects clk and rst in the enclosing module.
`ifndef AX25_HEADER_PARSER_MACROS_SVH
`define AX25_HEADER_PARSER_MACROS_SVH

// Same-cycle implication.
`define AX25HP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AX25HP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ax25hp_pkg.sv =====
`default_nettype none
package ax25hp_pkg;

  localparam int MAX_DIGIS   = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int ADDR_W      = 46;

  localparam logic [7:0] FT_I    = 8'h00;
  localparam logic [7:0] FT_UI   = 8'h03;
  localparam logic [7:0] SEG_PID = 8'h08;

  typedef enum logic [2:0] {
    PH_ADDR, PH_COMP, PH_DIGI, PH_CTRL, PH_CTRL2, PH_PID, PH_SEG, PH_INNER
  } phase_t;

  typedef enum logic [2:0] {
    ST_COMPLETE  = 3'd0,
    ST_SHORT     = 3'd1,
    ST_IN_ADDR   = 3'd2,
    ST_NO_PID    = 3'd3,
    ST_DIGIS     = 3'd4,
    ST_SEGMENTED = 3'd5
  } status_t;

  // one classified frame byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       char_ok;
  } byte_item_t;

  typedef struct packed {
    status_t           status;
    logic              compressed;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] src;
    logic [1:0]        call_valid;
    logic [3:0]        digi_count;
    logic [7:0]        frame_type;
    logic [6:0]        seq_send;
    logic [6:0]        seq_recv;
    logic              poll_final;
    logic [7:0]        pid;
    logic [7:0]        segment_byte;
  } header_rec_t;

endpackage
`default_nettype wire

// ===== sv/ax25hp_front.sv =====
`default_nettype none
module ax25hp_front (
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             frame_byte,
  input  wire logic                   last_byte,
  input  wire logic                   full,
  output logic                        push,
  output ax25hp_pkg::byte_item_t      item
);

  // callsign character check on the shifted address byte
  function automatic logic char_ok(input logic [6:0] c);
    char_ok = (c == 7'h20) ||
              (c >= 7'h30 && c <= 7'h39) ||
              (c >= 7'h41 && c <= 7'h5A) ||
              (c >= 7'h61 && c <= 7'h7A);
  endfunction

  always_comb begin
    in_ready     = !full;
    push         = in_valid && !full;
    item.data    = frame_byte;
    item.last    = last_byte;
    item.char_ok = char_ok(frame_byte[7:1]);
  end

endmodule
`default_nettype wire

// ===== sv/ax25hp_fifo.sv =====
`default_nettype none
`include "ax25_header_parser_macros.svh"
module ax25hp_fifo #(
  parameter int DEPTH = ax25hp_pkg::QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire ax25hp_pkg::byte_item_t push_item,
  output logic                        full,
  input  wire logic                   pop,
  output ax25hp_pkg::byte_item_t      head,
  output logic                        head_valid
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  ax25hp_pkg::byte_item_t q [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  `AX25HP_ASSERT_NXT(a_fifo_grow, push && !pop, count == $past(count) + CW'(1), "queue count")
  `AX25HP_ASSERT_NXT(a_fifo_drain, pop && !push, count == $past(count) - CW'(1), "queue count")

endmodule
`default_nettype wire

// ===== sv/ax25hp_back.sv =====
`default_nettype none
`include "ax25_header_parser_macros.svh"
module ax25hp_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   ext_seq,
  input  wire ax25hp_pkg::byte_item_t head,
  input  wire logic                   head_valid,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output ax25hp_pkg::header_rec_t     rec
);

  localparam int AW = ax25hp_pkg::ADDR_W;
  localparam logic [3:0] MAXD = 4'(ax25hp_pkg::MAX_DIGIS);

  ax25hp_pkg::phase_t  phase, phase_next;
  ax25hp_pkg::status_t done_status, done_status_next;
  logic [3:0]    pos, pos_next;
  logic [3:0]    frame_len, frame_len_next;
  logic [AW-1:0] dest_acc, dest_acc_next;
  logic [AW-1:0] src_acc, src_acc_next;
  logic [AW-1:0] addr_work, addr_work_next;
  logic [1:0]    valid_flags, valid_flags_next;
  logic [1:0]    addr_done, addr_done_next;
  logic [3:0]    digi_cnt, digi_cnt_next;
  logic [7:0]    pid_hold, pid_hold_next;
  logic          compressed, compressed_next;
  logic          header_done, header_done_next;
  logic [7:0]    ftype, ftype_next;
  logic [6:0]    ns, ns_next;
  logic [6:0]    nr, nr_next;
  logic          pf, pf_next;
  logic [7:0]    seg, seg_next;

  ax25hp_pkg::header_rec_t rec_next;
  logic          rec_load;
  logic [7:0]    b;
  logic [39:0]   comp_w;
  logic [AW-1:0] comp_dest;
  logic [7:0]    ft_new;

  always_comb begin
    b      = head.data;
    comp_w = {addr_work[31:0], head.data};
    comp_dest = '0;
    for (int i = 0; i < 6; i++) begin
      comp_dest[AW-1-7*i -: 7] = 7'h20 + {1'b0, comp_w[39-6*i -: 6]};
    end
    comp_dest[3:0] = comp_w[3:0];
  end

  always_comb begin
    pop = head_valid && (!head.last || !out_valid || out_ready);

    phase_next       = phase;
    done_status_next = done_status;
    pos_next         = pos;
    frame_len_next   = frame_len;
    dest_acc_next    = dest_acc;
    src_acc_next     = src_acc;
    addr_work_next   = addr_work;
    valid_flags_next = valid_flags;
    addr_done_next   = addr_done;
    digi_cnt_next    = digi_cnt;
    pid_hold_next    = pid_hold;
    compressed_next  = compressed;
    header_done_next = header_done;
    ftype_next       = ftype;
    ns_next          = ns;
    nr_next          = nr;
    pf_next          = pf;
    seg_next         = seg;
    ft_new           = ftype;
    rec_next         = '0;
    rec_load         = 1'b0;

    if (pop) begin
      if (frame_len != 4'd8) begin
        frame_len_next = frame_len + 4'd1;
      end
      if (!header_done) begin
        unique case (phase)
          ax25hp_pkg::PH_ADDR: begin
            if (pos == 4'd1 && b[0]) begin
              compressed_next = 1'b1;
              phase_next      = ax25hp_pkg::PH_COMP;
              pos_next        = 4'd2;
              addr_work_next  = '0;
            end else if (pos != 4'd6 && pos != 4'd13) begin
              if (!head.char_ok) begin
                valid_flags_next = valid_flags & ((pos < 4'd7) ? 2'b10 : 2'b01);
              end
              addr_work_next = {addr_work[AW-8:0], b[7:1]};
              pos_next       = pos + 4'd1;
            end else if (pos == 4'd6) begin
              dest_acc_next  = {addr_work[AW-5:0], b[4:1]};
              addr_done_next = addr_done | 2'b01;
              addr_work_next = '0;
              pos_next       = pos + 4'd1;
            end else begin
              src_acc_next   = {addr_work[AW-5:0], b[4:1]};
              addr_done_next = addr_done | 2'b10;
              addr_work_next = '0;
              pos_next       = '0;
              phase_next     = b[0] ? ax25hp_pkg::PH_CTRL : ax25hp_pkg::PH_DIGI;
            end
          end
          ax25hp_pkg::PH_COMP: begin
            addr_work_next = {addr_work[AW-9:0], b};
            if (pos >= 4'd6) begin
              dest_acc_next  = comp_dest;
              addr_done_next = addr_done | 2'b01;
              addr_work_next = '0;
              pos_next       = '0;
              phase_next     = ax25hp_pkg::PH_CTRL;
            end else begin
              pos_next = pos + 4'd1;
            end
          end
          ax25hp_pkg::PH_DIGI: begin
            if (pos == 4'd0 && digi_cnt >= MAXD) begin
              header_done_next = 1'b1;
              done_status_next = ax25hp_pkg::ST_DIGIS;
            end else begin
              if (pos == 4'd0) begin
                digi_cnt_next = digi_cnt + 4'd1;
              end
              if (pos >= 4'd6) begin
                pos_next = '0;
                if (b[0]) begin
                  phase_next = ax25hp_pkg::PH_CTRL;
                end
              end else begin
                pos_next = pos + 4'd1;
              end
            end
          end
          ax25hp_pkg::PH_CTRL: begin
            if (!compressed && ext_seq) begin
              if (!b[0]) begin
                ft_new     = ax25hp_pkg::FT_I;
                ns_next    = b[7:1];
                phase_next = ax25hp_pkg::PH_CTRL2;
              end else if (b[1]) begin
                ft_new  = b & 8'hEF;
                pf_next = b[4];
              end else begin
                ft_new     = b;
                phase_next = ax25hp_pkg::PH_CTRL2;
              end
            end else begin
              pf_next = b[4];
              if (!b[0]) begin
                ft_new  = ax25hp_pkg::FT_I;
                ns_next = {4'd0, b[3:1]};
                nr_next = {4'd0, b[7:5]};
              end else if (b[1]) begin
                ft_new = b & 8'hEF;
              end else begin
                ft_new  = b & 8'h0F;
                nr_next = {4'd0, b[7:5]};
              end
            end
            ftype_next = ft_new;
            // two-byte forms continue in the second control byte
            if (phase_next == ax25hp_pkg::PH_CTRL) begin
              if (ft_new == ax25hp_pkg::FT_I || ft_new == ax25hp_pkg::FT_UI) begin
                phase_next = ax25hp_pkg::PH_PID;
              end else begin
                header_done_next = 1'b1;
                done_status_next = ax25hp_pkg::ST_COMPLETE;
              end
            end
          end
          ax25hp_pkg::PH_CTRL2: begin
            nr_next = b[7:1];
            pf_next = b[0];
            if (ftype == ax25hp_pkg::FT_I || ftype == ax25hp_pkg::FT_UI) begin
              phase_next = ax25hp_pkg::PH_PID;
            end else begin
              header_done_next = 1'b1;
              done_status_next = ax25hp_pkg::ST_COMPLETE;
            end
          end
          ax25hp_pkg::PH_PID: begin
            pid_hold_next = b;
            if (b == ax25hp_pkg::SEG_PID) begin
              phase_next = ax25hp_pkg::PH_SEG;
            end else begin
              header_done_next = 1'b1;
              done_status_next = ax25hp_pkg::ST_COMPLETE;
            end
          end
          ax25hp_pkg::PH_SEG: begin
            seg_next = b;
            if (b[7]) begin
              phase_next = ax25hp_pkg::PH_INNER;
            end else begin
              header_done_next = 1'b1;
              done_status_next = ax25hp_pkg::ST_SEGMENTED;
            end
          end
          ax25hp_pkg::PH_INNER: begin
            pid_hold_next    = b;
            header_done_next = 1'b1;
            done_status_next = ax25hp_pkg::ST_SEGMENTED;
          end
          default: begin
            phase_next = ax25hp_pkg::PH_ADDR;
          end
        endcase
      end

      if (head.last) begin
        rec_load = 1'b1;
        if (frame_len_next < 4'd8) begin
          rec_next.status = ax25hp_pkg::ST_SHORT;
        end else begin
          if (header_done_next) begin
            rec_next.status = done_status_next;
          end else if (phase_next == ax25hp_pkg::PH_ADDR ||
                       phase_next == ax25hp_pkg::PH_COMP ||
                       phase_next == ax25hp_pkg::PH_DIGI ||
                       phase_next == ax25hp_pkg::PH_CTRL) begin
            rec_next.status = ax25hp_pkg::ST_IN_ADDR;
          end else begin
            rec_next.status = ax25hp_pkg::ST_NO_PID;
          end
          rec_next.compressed = compressed_next;
          rec_next.dest       = dest_acc_next;
          rec_next.src        = compressed_next ? '0 : src_acc_next;
          rec_next.call_valid = compressed_next ? 2'b00 : (valid_flags_next & addr_done_next);
          rec_next.digi_count = digi_cnt_next;
          if (rec_next.status != ax25hp_pkg::ST_DIGIS) begin
            rec_next.frame_type   = ftype_next;
            rec_next.seq_send     = ns_next;
            rec_next.seq_recv     = nr_next;
            rec_next.poll_final   = pf_next;
            rec_next.pid          = pid_hold_next;
            rec_next.segment_byte = seg_next;
          end
        end
        // start the next frame clean
        phase_next       = ax25hp_pkg::PH_ADDR;
        done_status_next = ax25hp_pkg::ST_COMPLETE;
        pos_next         = '0;
        frame_len_next   = '0;
        dest_acc_next    = '0;
        src_acc_next     = '0;
        addr_work_next   = '0;
        valid_flags_next = 2'b11;
        addr_done_next   = '0;
        digi_cnt_next    = '0;
        pid_hold_next    = '0;
        compressed_next  = 1'b0;
        header_done_next = 1'b0;
        ftype_next       = '0;
        ns_next          = '0;
        nr_next          = '0;
        pf_next          = 1'b0;
        seg_next         = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ax25hp_pkg::PH_ADDR;
      done_status <= ax25hp_pkg::ST_COMPLETE;
      pos         <= '0;
      frame_len   <= '0;
      dest_acc    <= '0;
      src_acc     <= '0;
      addr_work   <= '0;
      valid_flags <= 2'b11;
      addr_done   <= '0;
      digi_cnt    <= '0;
      pid_hold    <= '0;
      compressed  <= 1'b0;
      header_done <= 1'b0;
      ftype       <= '0;
      ns          <= '0;
      nr          <= '0;
      pf          <= 1'b0;
      seg         <= '0;
      out_valid   <= 1'b0;
    end else begin
      phase       <= phase_next;
      done_status <= done_status_next;
      pos         <= pos_next;
      frame_len   <= frame_len_next;
      dest_acc    <= dest_acc_next;
      src_acc     <= src_acc_next;
      addr_work   <= addr_work_next;
      valid_flags <= valid_flags_next;
      addr_done   <= addr_done_next;
      digi_cnt    <= digi_cnt_next;
      pid_hold    <= pid_hold_next;
      compressed  <= compressed_next;
      header_done <= header_done_next;
      ftype       <= ftype_next;
      ns          <= ns_next;
      nr          <= nr_next;
      pf          <= pf_next;
      seg         <= seg_next;
      if (rec_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_load) begin
      rec <= rec_next;
    end
  end

  `AX25HP_ASSERT_NXT(a_last_gives_rec, pop && head.last, out_valid, "record not raised")
  `AX25HP_ASSERT_IMP(a_comp_phase, phase == ax25hp_pkg::PH_COMP, compressed, "comp phase flag")
  `AX25HP_ASSERT_IMP(a_digi_rec, out_valid && rec.status == ax25hp_pkg::ST_DIGIS, rec.pid == 8'h00 && rec.frame_type == 8'h00, "digi record fields")

endmodule
`default_nettype wire

// ===== sv/ax25_header_parser.sv =====
// A record is offered from the output register once the item carrying last_byte
// has passed through the queue and been taken by the parser.
// Throughput: one frame byte per cycle; the parser consumes one queued item per cycle.
// A record held at the output stops the parser at the next frame's final byte;
// input stalls once the four-entry queue behind it is full.
// Reset (rst, synchronous, active high) empties the queue, clears the parser,
// drops any held record and clears the stored extended_sequence setting to 0.
`default_nettype none
module ax25_header_parser #(
  parameter int QUEUE_DEPTH = ax25hp_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_write,
  input  wire logic        extended_sequence,
  // byte input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        last_byte,
  // header record output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic             compressed_header,
  output logic [45:0]      dest_address,
  output logic [45:0]      src_address,
  output logic [1:0]       call_valid,
  output logic [3:0]       digi_count,
  output logic [7:0]       frame_type,
  output logic [6:0]       seq_send,
  output logic [6:0]       seq_recv,
  output logic             poll_final,
  output logic [7:0]       pid,
  output logic [7:0]       segment_byte
);

  // modulo-128 control field select; user must set it only between frames, unenforced
  logic ext_seq;

  ax25hp_pkg::byte_item_t  push_item;
  ax25hp_pkg::byte_item_t  head;
  ax25hp_pkg::header_rec_t rec;
  logic push;
  logic full;
  logic pop;
  logic head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_seq <= 1'b0;
    end else if (cfg_write) begin
      ext_seq <= extended_sequence;
    end
  end

  // front: take bytes, tag with the callsign character check
  ax25hp_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .frame_byte (frame_byte),
    .last_byte  (last_byte),
    .full       (full),
    .push       (push),
    .item       (push_item)
  );

  // short queue between front and parser
  ax25hp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // back: header state machine and output register
  ax25hp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .ext_seq    (ext_seq),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rec        (rec)
  );

  assign status            = rec.status;
  assign compressed_header = rec.compressed;
  assign dest_address      = rec.dest;
  assign src_address       = rec.src;
  assign call_valid        = rec.call_valid;
  assign digi_count        = rec.digi_count;
  assign frame_type        = rec.frame_type;
  assign seq_send          = rec.seq_send;
  assign seq_recv          = rec.seq_recv;
  assign poll_final        = rec.poll_final;
  assign pid               = rec.pid;
  assign segment_byte      = rec.segment_byte;

endmodule
`default_nettype wire

// ===== bench/ax25_header_parser_checker.sv =====
// Watches both item channels, predicts one header record per frame and
// compares it field by field with what the parser hands out.
module ax25_header_parser_checker
  import ax25hp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        extended_sequence,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  frame_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic        compressed_header,
  input  logic [45:0] dest_address,
  input  logic [45:0] src_address,
  input  logic [1:0]  call_valid,
  input  logic [3:0]  digi_count,
  input  logic [7:0]  frame_type,
  input  logic [6:0]  seq_send,
  input  logic [6:0]  seq_recv,
  input  logic        poll_final,
  input  logic [7:0]  pid,
  input  logic [7:0]  segment_byte,
  output int          mismatches,
  output int          pending
);

  // predictor state, one frame at a time
  logic        mod128;
  int unsigned pos;
  phase_t      phase;
  logic [45:0] dest_acc, src_acc, shift_acc;
  logic [1:0]  chars_ok, addr_seen;
  int unsigned digis, frame_len;
  logic        comp, hdr_done;
  status_t     done_st;
  logic [7:0]  ftype, pid_r, seg_r;
  logic [6:0]  ns, nr;
  logic        pf;

  header_rec_t hdr_expected[$];

  function automatic logic is_call_char(input logic [6:0] c);
    return c == 7'h20 || (c >= 7'h30 && c <= 7'h39) ||
           (c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A);
  endfunction

  task automatic clear_frame();
    pos = 0;
    phase = PH_ADDR;
    dest_acc = '0;
    src_acc = '0;
    shift_acc = '0;
    chars_ok = 2'b11;
    addr_seen = 2'b00;
    digis = 0;
    frame_len = 0;
    comp = 1'b0;
    hdr_done = 1'b0;
    done_st = ST_COMPLETE;
    ftype = '0;
    pid_r = '0;
    seg_r = '0;
    ns = '0;
    nr = '0;
    pf = 1'b0;
  endtask

  task automatic header_ends(input status_t st);
    hdr_done = 1'b1;
    done_st = st;
  endtask

  // only I and UI frames go on to a pid
  task automatic end_of_control();
    if (ftype == FT_I || ftype == FT_UI) phase = PH_PID;
    else header_ends(ST_COMPLETE);
  endtask

  task automatic take_header_byte(input logic [7:0] b);
    logic [45:0] d;
    case (phase)
      PH_ADDR: begin
        if (pos == 1 && b[0]) begin
          comp = 1'b1;
          phase = PH_COMP;
          pos = 2;
          shift_acc = '0;
        end else if (pos % 7 < 6) begin
          if (!is_call_char(b[7:1])) chars_ok &= (pos < 7) ? 2'b10 : 2'b01;
          shift_acc = {shift_acc[38:0], b[7:1]};
          pos++;
        end else begin
          shift_acc = {shift_acc[41:0], b[4:1]};
          if (pos < 7) begin
            dest_acc = shift_acc;
            addr_seen[0] = 1'b1;
            shift_acc = '0;
            pos++;
          end else begin
            src_acc = shift_acc;
            addr_seen[1] = 1'b1;
            shift_acc = '0;
            pos = 0;
            phase = b[0] ? PH_CTRL : PH_DIGI;
          end
        end
      end
      PH_COMP: begin
        shift_acc = {shift_acc[37:0], b};
        if (pos >= 6) begin
          d = '0;
          for (int i = 0; i < 6; i++)
            d = {d[38:0], 7'h20 + {1'b0, shift_acc[34-6*i +: 6]}};
          dest_acc = {d[41:0], shift_acc[3:0]};
          addr_seen[0] = 1'b1;
          shift_acc = '0;
          pos = 0;
          phase = PH_CTRL;
        end else begin
          pos++;
        end
      end
      PH_DIGI: begin
        if (pos == 0 && digis >= MAX_DIGIS) begin
          header_ends(ST_DIGIS);
        end else begin
          if (pos == 0) digis++;
          if (pos >= 6) begin
            pos = 0;
            if (b[0]) phase = PH_CTRL;
          end else begin
            pos++;
          end
        end
      end
      PH_CTRL: begin
        if (!comp && mod128) begin
          if (!b[0]) begin
            ftype = FT_I;
            ns = b[7:1];
            phase = PH_CTRL2;
          end else if (b[1]) begin
            ftype = b & 8'hEF;
            pf = b[4];
            end_of_control();
          end else begin
            ftype = b;
            phase = PH_CTRL2;
          end
        end else begin
          pf = b[4];
          if (!b[0]) begin
            ftype = FT_I;
            ns = {4'b0, b[3:1]};
            nr = {4'b0, b[7:5]};
          end else if (b[1]) begin
            ftype = b & 8'hEF;
          end else begin
            ftype = b & 8'h0F;
            nr = {4'b0, b[7:5]};
          end
          end_of_control();
        end
      end
      PH_CTRL2: begin
        nr = b[7:1];
        pf = b[0];
        end_of_control();
      end
      PH_PID: begin
        pid_r = b;
        if (b == SEG_PID) phase = PH_SEG;
        else header_ends(ST_COMPLETE);
      end
      PH_SEG: begin
        seg_r = b;
        if (b[7]) phase = PH_INNER;
        else header_ends(ST_SEGMENTED);
      end
      default: begin
        pid_r = b;
        header_ends(ST_SEGMENTED);
      end
    endcase
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic fin);
    header_rec_t r;
    status_t st;
    if (frame_len < 8) frame_len++;
    if (!hdr_done) take_header_byte(b);
    if (fin) begin
      r = '0;
      if (frame_len < 8) begin
        r.status = ST_SHORT;
      end else begin
        if (hdr_done) st = done_st;
        else if (phase <= PH_CTRL) st = ST_IN_ADDR;
        else st = ST_NO_PID;
        r.status = st;
        r.compressed = comp;
        r.dest = dest_acc;
        if (!comp) begin
          r.src = src_acc;
          r.call_valid = chars_ok & addr_seen;
        end
        r.digi_count = 4'(digis);
        if (st != ST_DIGIS) begin
          r.frame_type = ftype;
          r.seq_send = ns;
          r.seq_recv = nr;
          r.poll_final = pf;
          r.pid = pid_r;
          r.segment_byte = seg_r;
        end
      end
      hdr_expected.push_back(r);
      clear_frame();
    end
  endtask

  task automatic check_field(input string name, input logic [45:0] got,
                             input logic [45:0] want);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    header_rec_t want;
    if (rst) begin
      mod128 = 1'b0;
      clear_frame();
      hdr_expected.delete();
    end else begin
      if (cfg_write) mod128 = extended_sequence;
      if (out_valid && out_ready) begin
        if (hdr_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("header record with none expected, status %0d", status);
        end else begin
          want = hdr_expected.pop_front();
          check_field("status", status, want.status);
          check_field("compressed_header", compressed_header, want.compressed);
          check_field("dest_address", dest_address, want.dest);
          check_field("src_address", src_address, want.src);
          check_field("call_valid", call_valid, want.call_valid);
          check_field("digi_count", digi_count, want.digi_count);
          check_field("frame_type", frame_type, want.frame_type);
          check_field("seq_send", seq_send, want.seq_send);
          check_field("seq_recv", seq_recv, want.seq_recv);
          check_field("poll_final", poll_final, want.poll_final);
          check_field("pid", pid, want.pid);
          check_field("segment_byte", segment_byte, want.segment_byte);
        end
      end
      if (in_valid && in_ready) predict_byte(frame_byte, last_byte);
    end
    pending = hdr_expected.size();
  end

endmodule

// ===== bench/tb_ax25_header_parser.sv =====
// Top of the bench: clock, reset, frame stimulus, mode changes and verdict.
// All checking lives in the checker instance beside the parser.
module tb_ax25_header_parser;
  import ax25hp_pkg::*;

  localparam int ITEMS = 1150;  // frame bytes to send in all

  // kinds of control field the frame builder produces
  typedef enum int {CTL_I, CTL_S, CTL_U, CTL_UI} ctl_kind_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        extended_sequence;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  frame_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  status;
  logic        compressed_header;
  logic [45:0] dest_address;
  logic [45:0] src_address;
  logic [1:0]  call_valid;
  logic [3:0]  digi_count;
  logic [7:0]  frame_type;
  logic [6:0]  seq_send;
  logic [6:0]  seq_recv;
  logic        poll_final;
  logic [7:0]  pid;
  logic [7:0]  segment_byte;
  int          mismatches;
  int          pending;

  logic [7:0]  frame_q[$];     // bytes of the frame being sent
  logic        mod128_now;     // mode the builder shapes control fields for
  int          sent_items;     // frame bytes sent so far, payload included
  logic        send_calm;      // sender runs without gaps while set
  logic        recv_calm;      // receiver waits only on long holds while set

  ax25_header_parser i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .extended_sequence(extended_sequence),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .frame_byte       (frame_byte),
    .last_byte        (last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .compressed_header(compressed_header),
    .dest_address     (dest_address),
    .src_address      (src_address),
    .call_valid       (call_valid),
    .digi_count       (digi_count),
    .frame_type       (frame_type),
    .seq_send         (seq_send),
    .seq_recv         (seq_recv),
    .poll_final       (poll_final),
    .pid              (pid),
    .segment_byte     (segment_byte)
  );

  ax25_header_parser_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .extended_sequence(extended_sequence),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .frame_byte       (frame_byte),
    .last_byte        (last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .compressed_header(compressed_header),
    .dest_address     (dest_address),
    .src_address      (src_address),
    .call_valid       (call_valid),
    .digi_count       (digi_count),
    .frame_type       (frame_type),
    .seq_send         (seq_send),
    .seq_recv         (seq_recv),
    .poll_final       (poll_final),
    .pid              (pid),
    .segment_byte     (segment_byte),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Byte channel. Random gap before each item, with calm stretches of
  // back-to-back items. Valid holds with its payload until accepted.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int g;
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    g = send_calm ? 0 : $urandom_range(0, 18);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_valid   <= 1'b1;
    frame_byte <= b;
    last_byte  <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Mode change only with the parser drained: every record back, then an extra
  // idle wait before the configuration write.
  task automatic write_mode(input logic v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_write <= 1'b1;
    extended_sequence <= v;
    mod128_now = v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // directed frames are packed first byte at the top
  task automatic load_frame(input logic [95:0] bytes, input int n);
    frame_q.delete();
    for (int i = 0; i < n; i++) frame_q.push_back(bytes[8*(n-1-i) +: 8]);
    sent_items += n;
  endtask

  // ---------------------------------------------------------------------------
  // Frame builder
  // ---------------------------------------------------------------------------

  // Callsign character, shifted left one as on the air. Mostly legal
  // characters (space, digits, both cases), now and then any 7-bit value.
  function automatic logic [7:0] call_char();
    int r;
    logic [6:0] c;
    r = $urandom_range(0, 69);
    if (r == 0) c = 7'h20;
    else if (r <= 10) c = 7'h30 + 7'(r - 1);
    else if (r <= 36) c = 7'h41 + 7'(r - 11);
    else if (r <= 62) c = 7'h61 + 7'(r - 37);
    else c = 7'($urandom);
    return {c, 1'b0};
  endfunction

  // six characters plus SSID byte; fin sets the end-of-address bit
  task automatic add_address(input logic fin);
    repeat (6) frame_q.push_back(call_char());
    frame_q.push_back({3'($urandom), 4'($urandom), fin});
  endtask

  // Control field, second byte for I and S in modulo-128 mode (never for the
  // compressed form), then pid and segmentation bytes where the type has them.
  task automatic add_control(input logic is_comp);
    ctl_kind_t kind;
    logic [7:0] c;
    logic wide;
    kind = ctl_kind_t'($urandom_range(0, 3));
    wide = mod128_now && !is_comp;
    c = 8'($urandom);
    case (kind)
      CTL_I: c[0] = 1'b0;
      CTL_S: c[1:0] = 2'b01;
      CTL_U: c[1:0] = 2'b11;
      default: c = FT_UI | {3'b000, c[4], 4'b0000};
    endcase
    frame_q.push_back(c);
    if (wide && (kind == CTL_I || kind == CTL_S)) frame_q.push_back(8'($urandom));
    // a random U byte can land on UI too
    if (kind == CTL_I || (kind != CTL_S && (c & 8'hEF) == FT_UI)) begin
      if ($urandom_range(0, 3) == 0) begin
        frame_q.push_back(SEG_PID);
        c = 8'($urandom);
        frame_q.push_back(c);
        if (c[7]) frame_q.push_back(8'($urandom));  // first segment: inner pid
      end else begin
        frame_q.push_back(8'($urandom));
      end
    end
  endtask

  // Mostly well-formed frames with random content: full address headers
  // (sometimes past the digipeater limit) and compressed headers. The rest is
  // short frames, raw noise and frames cut off anywhere after byte eight.
  task automatic build_random_frame();
    int pick, n_digi, cut;
    frame_q.delete();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 7)) frame_q.push_back(8'($urandom));
    end else if (pick < 14) begin
      repeat ($urandom_range(8, 24)) frame_q.push_back(8'($urandom));
    end else if (pick < 36) begin
      frame_q.push_back(8'($urandom));
      frame_q.push_back(8'($urandom) | 8'h01);  // compressed marker
      repeat (5) frame_q.push_back(8'($urandom));
      add_control(1'b1);
    end else begin
      n_digi = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 2);
      add_address(1'($urandom));
      add_address(n_digi == 0);
      for (int i = 0; i < n_digi; i++) add_address(i == n_digi - 1);
      add_control(1'b0);
    end
    repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));  // payload
    if (frame_q.size() > 8 && $urandom_range(0, 6) == 0) begin
      cut = $urandom_range(8, frame_q.size() - 1);
      while (frame_q.size() > cut) void'(frame_q.pop_back());
    end
    sent_items += frame_q.size();
  endtask

  // ---------------------------------------------------------------------------
  // Record channel. Random hold-off before each item; now and then a long hold
  // so the output stays full, the parser queue fills and input stalls.
  // ---------------------------------------------------------------------------
  initial begin : drain
    int w;
    int taken;
    out_ready = 1'b0;
    recv_calm = 1'b0;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
      w = recv_calm ? 0 : $urandom_range(0, 18);
      if (taken % 20 == 12) w = 300;
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst = 1'b1;
    cfg_write = 1'b0;
    extended_sequence = 1'b0;
    in_valid = 1'b0;
    frame_byte = '0;
    last_byte = 1'b0;
    mod128_now = 1'b0;
    sent_items = 0;
    send_calm = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed frames; compressed headers decode modulo 8 whatever the mode
    write_mode(1'b1);
    // single all-ones byte: short frame
    load_frame(96'hFF, 1);
    send_frame();
    // compressed UI with poll set, first segment with inner pid
    load_frame(96'h00_FF_FF_00_FF_00_FF_13_08_80_CC, 11);
    send_frame();
    // compressed I with all sequence bits set, later segment (no inner pid)
    load_frame(96'hFF_01_00_00_00_00_00_FE_08_05, 10);
    send_frame();

    // random frames in six phases, mode alternating 0/1
    for (int ph = 0; ph < 6; ph++) begin
      write_mode(ph[0]);
      while (sent_items < (ph + 1) * ITEMS / 6) begin
        build_random_frame();
        send_frame();
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);  // catch any stray record
    if (mismatches == 0)
      $display("** ax25_header_parser: PASSED **");
    else
      $display("** ax25_header_parser: FAILED **");
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin : watchdog
    #1000000;
    $display("** ax25_header_parser: FAILED **");
    $finish;
  end

endmodule
